// File: hdl/spsa_pkg.sv
// shared types and constants of the sprite sheet frame animator
// used by the register block, the shared divider and the top level
package spsa_pkg;

    localparam int FRAME_W = 12;
    localparam int TICK_W  = 16;
    localparam int GRID_W  = 7;
    localparam int COORD_W = 17;
    localparam int ACC_W   = 29;
    localparam int SPAN_W  = 13;
    localparam int DVD_W   = 29;
    localparam int DIV_W   = 16;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int OUT_W   = FRAME_W + 4 * COORD_W;

    localparam logic [COORD_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [2:0] {
        REG_FIRST_FRAME   = 3'd0,
        REG_LAST_FRAME    = 3'd1,
        REG_FRAME_TICKS   = 3'd2,
        REG_SHEET_COLUMNS = 3'd3,
        REG_SHEET_ROWS    = 3'd4
    } spsa_reg_t;

    typedef struct packed {
        logic [FRAME_W-1:0] first_frame;
        logic [FRAME_W-1:0] last_frame;
        logic [TICK_W-1:0]  frame_ticks;
        logic [GRID_W-1:0]  sheet_columns;
        logic [GRID_W-1:0]  sheet_rows;
    } spsa_cfg_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem_init;
        logic [DVD_W-1:0] dividend;
        logic [CNT_W-1:0] nbits;
        logic [DIV_W-1:0] divisor;
    } spsa_div_req_t;

endpackage

// File: hdl/spsa_cfg_regs.sv
// apb configuration registers of the frame animator
// depends on spsa_pkg for the register map and the config struct
module spsa_cfg_regs import spsa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output spsa_cfg_t         cfg
);

    spsa_cfg_t cfg_reg;
    spsa_reg_t sel;

    assign sel    = spsa_reg_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_frame   <= '0;
            cfg_reg.last_frame    <= '0;
            cfg_reg.frame_ticks   <= 16'd1;
            cfg_reg.sheet_columns <= 7'd1;
            cfg_reg.sheet_rows    <= 7'd1;
        end else if (psel && penable && pwrite) begin
            case (sel)
                REG_FIRST_FRAME:   cfg_reg.first_frame   <= pwdata[FRAME_W-1:0];
                REG_LAST_FRAME:    cfg_reg.last_frame    <= pwdata[FRAME_W-1:0];
                REG_FRAME_TICKS:   cfg_reg.frame_ticks   <= pwdata[TICK_W-1:0];
                REG_SHEET_COLUMNS: cfg_reg.sheet_columns <= pwdata[GRID_W-1:0];
                REG_SHEET_ROWS:    cfg_reg.sheet_rows    <= pwdata[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_FIRST_FRAME:   prdata = DATA_W'(cfg_reg.first_frame);
            REG_LAST_FRAME:    prdata = DATA_W'(cfg_reg.last_frame);
            REG_FRAME_TICKS:   prdata = DATA_W'(cfg_reg.frame_ticks);
            REG_SHEET_COLUMNS: prdata = DATA_W'(cfg_reg.sheet_columns);
            REG_SHEET_ROWS:    prdata = DATA_W'(cfg_reg.sheet_rows);
            default:           prdata = '0;
        endcase
    end

endmodule

// File: hdl/spsa_div_unit.sv
// shared restoring divider, one quotient bit per cycle
// depends on spsa_pkg for the request struct and widths
module spsa_div_unit import spsa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  spsa_div_req_t    req,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   rem_sub;
    logic             fits;

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dsr_reg};
        fits     = rem_sh >= {1'b0, dsr_reg};
        rem_next = fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
                rem_reg  <= req.rem_init;
                dvd_reg  <= req.dividend;
                dsr_reg  <= req.divisor;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/sprite_sheet_frame_animator.sv
// sprite sheet frame animator: one item in, one texture rectangle out
// the shared divider does the work in order: time / frame_ticks, the row and column split,
// then one division per coordinate (skipped when a coordinate saturates); a new item is
// taken only when the sequencer is back in idle, and the next item is taken while the
// previous result waits for m_tready
// synchronous active-low reset clears the accumulator and the sequencer and loads the register defaults
module sprite_sheet_frame_animator import spsa_pkg::*; #(
    parameter int MAX_GRID = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,  // elapsed_ticks
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata   // frame_index, u_start, v_start, u_end, v_end
);

    localparam int GW = $clog2(MAX_GRID + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LEN, ST_WRAP, ST_DIVT, ST_IDX, ST_DIVRC, ST_RAT, ST_RWAIT, ST_FINISH
    } st_t;

    spsa_cfg_t         cfg;
    spsa_div_req_t     div_req_reg, div_req_next;
    logic              div_start_reg, div_start_next;
    logic              div_busy, div_done;
    logic [DVD_W-1:0]  div_q;
    logic [DIV_W-1:0]  div_r;

    st_t               state_reg, state_next;
    logic [TICK_W-1:0] dt_reg, dt_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  len_reg, len_next;
    logic [FRAME_W-1:0] idx_reg, idx_next;
    logic [FRAME_W-1:0] row_reg, row_next;
    logic [GW-1:0]     col_reg, col_next;
    logic [1:0]        sel_reg, sel_next;
    logic [COORD_W-1:0] rat_reg [4];
    logic [COORD_W-1:0] rat_next [4];
    logic              m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [TICK_W-1:0] ft;
    logic [GW-1:0]     cols, rows;
    logic [SPAN_W-1:0] span;
    logic [ACC_W-1:0]  wrapped;
    logic [SPAN_W-1:0] rat_n, rat_d;

    spsa_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spsa_div_unit u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .req       (div_req_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        ft = (cfg.frame_ticks == '0) ? TICK_W'(1) : cfg.frame_ticks;
        if (cfg.sheet_columns == '0) begin
            cols = GW'(1);
        end else if (32'(cfg.sheet_columns) > 32'(MAX_GRID)) begin
            cols = GW'(MAX_GRID);
        end else begin
            cols = GW'(cfg.sheet_columns);
        end
        if (cfg.sheet_rows == '0) begin
            rows = GW'(1);
        end else if (32'(cfg.sheet_rows) > 32'(MAX_GRID)) begin
            rows = GW'(MAX_GRID);
        end else begin
            rows = GW'(cfg.sheet_rows);
        end
        if (cfg.last_frame >= cfg.first_frame) begin
            span = SPAN_W'(cfg.last_frame) - SPAN_W'(cfg.first_frame) + SPAN_W'(1);
        end else begin
            span = SPAN_W'(1);
        end
        wrapped = (acc_reg >= len_reg) ? '0 : acc_reg;
        case (sel_reg)
            2'd0: begin
                rat_n = SPAN_W'(col_reg);
                rat_d = SPAN_W'(cols);
            end
            2'd1: begin
                rat_n = SPAN_W'(row_reg);
                rat_d = SPAN_W'(rows);
            end
            2'd2: begin
                rat_n = SPAN_W'(col_reg) + SPAN_W'(1);
                rat_d = SPAN_W'(cols);
            end
            default: begin
                rat_n = SPAN_W'(row_reg) + SPAN_W'(1);
                rat_d = SPAN_W'(rows);
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        dt_next        = dt_reg;
        acc_next       = acc_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        sel_next       = sel_reg;
        rat_next       = rat_reg;
        div_start_next = 1'b0;
        div_req_next   = div_req_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    dt_next    = s_tdata;
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                len_next   = ACC_W'(span) * ACC_W'(ft);
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                acc_next              = wrapped + ACC_W'(dt_reg);
                div_req_next.rem_init = '0;
                div_req_next.dividend = DVD_W'(wrapped);
                div_req_next.nbits    = CNT_W'(ACC_W);
                div_req_next.divisor  = ft;
                div_start_next        = 1'b1;
                state_next            = ST_DIVT;
            end
            ST_DIVT: begin
                if (div_done) begin
                    idx_next   = div_q[FRAME_W-1:0] + cfg.first_frame;
                    state_next = ST_IDX;
                end
            end
            ST_IDX: begin
                div_req_next.rem_init = '0;
                div_req_next.dividend = {idx_reg, {(DVD_W-FRAME_W){1'b0}}};
                div_req_next.nbits    = CNT_W'(FRAME_W);
                div_req_next.divisor  = DIV_W'(cols);
                div_start_next        = 1'b1;
                state_next            = ST_DIVRC;
            end
            ST_DIVRC: begin
                if (div_done) begin
                    row_next   = div_q[FRAME_W-1:0];
                    col_next   = div_r[GW-1:0];
                    sel_next   = 2'd0;
                    state_next = ST_RAT;
                end
            end
            ST_RAT: begin
                if (rat_n >= rat_d) begin
                    rat_next[sel_reg] = ONE_Q16;
                    sel_next          = sel_reg + 2'd1;
                    state_next        = (sel_reg == 2'd3) ? ST_FINISH : ST_RAT;
                end else begin
                    div_req_next.rem_init = DIV_W'(rat_n);
                    div_req_next.dividend = '0;
                    div_req_next.nbits    = CNT_W'(16);
                    div_req_next.divisor  = DIV_W'(rat_d);
                    div_start_next        = 1'b1;
                    state_next            = ST_RWAIT;
                end
            end
            ST_RWAIT: begin
                if (div_done) begin
                    rat_next[sel_reg] = div_q[COORD_W-1:0];
                    sel_next          = sel_reg + 2'd1;
                    state_next        = (sel_reg == 2'd3) ? ST_FINISH : ST_RAT;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {rat_reg[3], rat_reg[2], rat_reg[1], rat_reg[0], idx_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            len_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            div_start_reg <= div_start_next;
            m_tvalid_reg  <= m_tvalid_next;
            len_reg       <= len_next;
            dt_reg        <= dt_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            sel_reg       <= sel_next;
            rat_reg       <= rat_next;
            div_req_reg   <= div_req_next;
            m_tdata_reg   <= m_tdata_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the divider is never restarted while it is still iterating
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_busy)
        else $error("divider started while busy");

    // a division result only arrives while the sequencer waits for one
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVT || state_reg == ST_DIVRC || state_reg == ST_RWAIT))
        else $error("divider result outside a wait state");

    // the rectangle is never inverted
    a_rect_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[62:46] >= m_tdata[28:12]) && (m_tdata[79:63] >= m_tdata[45:29]))
        else $error("texture rectangle inverted");

endmodule

// File: verif/testbench.sv
// testbench for sprite_sheet_frame_animator: drives time steps and register writes,
// predicts each texture rectangle in a scoreboard class and checks every result item
// depends on spsa_pkg and the sprite_sheet_frame_animator rtl
module testbench;
    import spsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] v_end;
        logic [COORD_W-1:0] u_end;
        logic [COORD_W-1:0] v_start;
        logic [COORD_W-1:0] u_start;
        logic [FRAME_W-1:0] frame_index;
    } rect_t;

    class anim_scoreboard;
        int unsigned first_frame = 0;
        int unsigned last_frame = 0;
        int unsigned frame_ticks = 1;
        int unsigned sheet_columns = 1;
        int unsigned sheet_rows = 1;
        bit [31:0] anim_ticks = 0;
        rect_t pending_rects[$];
        int errors = 0;

        function void write_reg(spsa_reg_t r, logic [DATA_W-1:0] v);
            case (r)
                REG_FIRST_FRAME:   first_frame = v[FRAME_W-1:0];
                REG_LAST_FRAME:    last_frame = v[FRAME_W-1:0];
                REG_FRAME_TICKS:   frame_ticks = v[TICK_W-1:0];
                REG_SHEET_COLUMNS: sheet_columns = v[GRID_W-1:0];
                REG_SHEET_ROWS:    sheet_rows = v[GRID_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned grid(int unsigned v);
            if (v == 0)
                return 1;
            return (v > 64) ? 64 : v;
        endfunction

        function logic [COORD_W-1:0] q16_ratio(int unsigned n, int unsigned d);
            longint unsigned q;
            if (n >= d)
                return ONE_Q16;
            q = (longint'(n) << 16) / d;
            return q[COORD_W-1:0];
        endfunction

        function void note_step(logic [TICK_W-1:0] dt);
            int unsigned ft, cols, rows, span, len, idx, row, col;
            rect_t r;
            ft = (frame_ticks == 0) ? 1 : frame_ticks;
            cols = grid(sheet_columns);
            rows = grid(sheet_rows);
            span = (last_frame >= first_frame) ? last_frame - first_frame + 1 : 1;
            len = span * ft;
            if (anim_ticks >= len)
                anim_ticks = 0;
            idx = (anim_ticks / ft + first_frame) & 32'hFFF;
            row = idx / cols;
            col = idx % cols;
            r.frame_index = idx[FRAME_W-1:0];
            r.u_start = q16_ratio(col, cols);
            r.v_start = q16_ratio(row, rows);
            r.u_end = q16_ratio(col + 1, cols);
            r.v_end = q16_ratio(row + 1, rows);
            pending_rects.push_back(r);
            if (anim_ticks > 32'hFFFF_FFFF - dt)
                anim_ticks = 32'hFFFF_FFFF;
            else
                anim_ticks = anim_ticks + dt;
        endfunction

        function void compare_field(string name, logic [COORD_W-1:0] exp_v,
                                    logic [COORD_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_rect(logic [OUT_W-1:0] d);
            rect_t got, want;
            got = rect_t'(d);
            if (pending_rects.size() == 0) begin
                $error("result item with no step pending: %h", d);
                errors++;
                return;
            end
            want = pending_rects.pop_front();
            compare_field("frame_index", COORD_W'(want.frame_index), COORD_W'(got.frame_index));
            compare_field("u_start", want.u_start, got.u_start);
            compare_field("v_start", want.v_start, got.v_start);
            compare_field("u_end", want.u_end, got.u_end);
            compare_field("v_end", want.v_end, got.v_end);
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [TICK_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    anim_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;

    sprite_sheet_frame_animator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_step(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_rect(m_tdata);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    function automatic int unsigned rand_frame();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int unsigned rand_ticks();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return 65535;
        if (r < 14)
            return $urandom_range(1, 8);
        return $urandom_range(0, 65535);
    endfunction

    function automatic int unsigned rand_grid();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return 64;
        if (r < 4)
            return $urandom_range(65, 127);
        return $urandom_range(1, 64);
    endfunction

    function automatic logic [TICK_W-1:0] rand_dt(int unsigned ft);
        int unsigned top;
        top = (ft == 0) ? 2 : 2 * ft;
        if (top > 65535)
            top = 65535;
        case ($urandom_range(0, 9))
            0: return TICK_W'($urandom_range(0, 65535));
            1: return '0;
            2: return 16'hFFFF;
            default: return TICK_W'($urandom_range(0, top));
        endcase
    endfunction

    task automatic apb_write(input spsa_reg_t r, input logic [DATA_W-1:0] v);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {r, 2'b00};
        pwdata = v;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(r, v);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_rects.size() != 0)
            @(negedge aclk);
    endtask

    task automatic apply_setting(input int unsigned first, input int unsigned last,
                                 input int unsigned ft, input int unsigned cols,
                                 input int unsigned rows);
        s_tvalid = 1'b0;
        wait_drained();
        apb_write(REG_FIRST_FRAME, first);
        apb_write(REG_LAST_FRAME, last);
        apb_write(REG_FRAME_TICKS, ft);
        apb_write(REG_SHEET_COLUMNS, cols);
        apb_write(REG_SHEET_ROWS, rows);
    endtask

    task automatic send_step(input logic [TICK_W-1:0] dt);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = dt;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // result side back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int unsigned first, last, ft, cols, rows;
        int unsigned pct_choice[3];
        pct_choice = '{0, 15, 50};
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset setting: one frame, one cell
        send_idle_pct = 20;
        stall_pct = 20;
        send_step(16'h0000);
        send_step(16'hFFFF);

        // exact wrap at the animation length, rows past the sheet bottom
        apply_setting(10, 13, 3, 4, 3);
        send_step(3);
        send_step(3);
        send_step(3);
        send_step(3);
        send_step(5);
        send_step(7);
        send_step(16'hFFFF);
        send_step(0);

        // reversed interval, zero frame length, grid out of range
        apply_setting(4095, 0, 0, 0, 127);
        send_step(16'hFFFF);
        send_step(0);
        send_step(16'hFFFF);
        send_step(1);

        // longest animation, largest grid
        apply_setting(0, 4095, 65535, 127, 64);
        send_step(16'hFFFF);
        send_step(16'hFFFF);
        send_step(16'hFFFF);
        send_step(16'hFFFF);
        send_step(0);

        // length lowered under a running accumulator
        apply_setting(0, 2, 1, 1, 1);
        send_step(1);
        send_step(1);

        for (int ph = 0; ph < 14; ph++) begin
            first = rand_frame();
            if ($urandom_range(0, 3) == 0)
                last = rand_frame();
            else
                last = first + $urandom_range(0, 12);
            if (last > 4095)
                last = 4095;
            ft = rand_ticks();
            cols = rand_grid();
            rows = rand_grid();
            apply_setting(first, last, ft, cols, rows);
            send_idle_pct = pct_choice[$urandom_range(0, 2)];
            stall_pct = pct_choice[$urandom_range(0, 2)];
            repeat (128) send_step(rand_dt(ft));
        end

        s_tvalid = 1'b0;
        wait_drained();
        repeat (150) @(posedge aclk);
        if (sb.pending_rects.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_rects.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
hdl/spsa_pkg.sv
hdl/spsa_cfg_regs.sv
hdl/spsa_div_unit.sv
hdl/sprite_sheet_frame_animator.sv
verif/testbench.sv
